@@ src/fwt_pkg.sv @@
// ============================================================================
// Fenwick tree package
// Shared widths, opcodes, the command word passed from the front end to the
// execution back end, and the low-bit helper used by the tree walks.
// ============================================================================
package fwt_pkg;

    localparam int MAX_SIZE = 1024;
    localparam int ADDR_W   = $clog2(MAX_SIZE);
    localparam int IDX_W    = 11;
    localparam int WLK_W    = IDX_W + 1;
    localparam int DATA_W   = 64;
    localparam int OP_W     = 3;

    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [WLK_W-1:0]         wlk_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [OP_W-1:0]          op_t;

    localparam op_t OP_ADD    = 3'd0;
    localparam op_t OP_SET    = 3'd1;
    localparam op_t OP_PREFIX = 3'd2;
    localparam op_t OP_RANGE  = 3'd3;
    localparam op_t OP_LOWER  = 3'd4;
    localparam op_t OP_CLEAR  = 3'd5;

    typedef struct packed {
        op_t   op;
        logic  bad;
        idx_t  idx_a;
        idx_t  idx_am1;
        idx_t  idx_b;
        data_t value;
        idx_t  n;
        idx_t  lb_step;
    } cmd_t;

    function automatic wlk_t low_bit(wlk_t x);
        return x & (~x + WLK_W'(1));
    endfunction

endpackage

@@ src/fwt_req_if.sv @@
// ============================================================================
// Fenwick tree request channel
// Valid/ready channel carrying one request word.
// ============================================================================
interface fwt_req_if;
    logic                 valid;
    logic                 ready;
    fwt_pkg::op_t         opcode;
    fwt_pkg::idx_t        index_a;
    fwt_pkg::idx_t        index_b;
    fwt_pkg::data_t       value;

    modport source (output valid, output opcode, output index_a, output index_b,
                    output value, input ready);
    modport sink   (input valid, input opcode, input index_a, input index_b,
                    input value, output ready);
endinterface

@@ src/fwt_rsp_if.sv @@
// ============================================================================
// Fenwick tree response channel
// Valid/ready channel carrying one response word.
// ============================================================================
interface fwt_rsp_if;
    logic           valid;
    logic           ready;
    fwt_pkg::data_t result;
    logic           status;

    modport source (output valid, output result, output status, input ready);
    modport sink   (input valid, input result, input status, output ready);
endinterface

@@ src/fwt_front.sv @@
// ============================================================================
// Fenwick tree front end
// Holds the size register, accepts request words and turns each into a
// classified command with its range checks and walk setup precomputed.
// ============================================================================
module fwt_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write_en,
    input  fwt_pkg::idx_t       cfg_write_data,
    fwt_req_if.sink             req,
    input  logic                q_full,
    input  logic                init_busy,
    output logic                push,
    output fwt_pkg::cmd_t       cmd
);
    import fwt_pkg::*;

    idx_t size_reg;
    idx_t n;
    logic a_bad;
    logic b_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= IDX_W'(MAX_SIZE);
        end
        else if (cfg_write_en)
        begin
            size_reg <= cfg_write_data;
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            n = IDX_W'(1);
        end
        else if (size_reg > IDX_W'(MAX_SIZE))
        begin
            n = IDX_W'(MAX_SIZE);
        end
        else
        begin
            n = size_reg;
        end
    end

    assign a_bad = (req.index_a == '0) || (req.index_a > n);
    assign b_bad = (req.index_b == '0) || (req.index_b > n);

    always_comb
    begin
        cmd         = '0;
        cmd.op      = req.opcode;
        cmd.idx_a   = req.index_a;
        cmd.idx_am1 = req.index_a - IDX_W'(1);
        cmd.idx_b   = req.index_b;
        cmd.value   = req.value;
        cmd.n       = n;
        if (req.opcode inside {OP_ADD, OP_SET, OP_PREFIX})
        begin
            cmd.bad = a_bad;
        end
        else if (req.opcode == OP_RANGE)
        begin
            cmd.bad = a_bad || b_bad;
        end
        else
        begin
            cmd.bad = 1'b0;
        end
        for (int i = 0; i < IDX_W; i++)
        begin
            if (n[i])
            begin
                cmd.lb_step = IDX_W'(1) << i;
            end
        end
    end

    assign req.ready = !q_full && !init_busy;
    assign push      = req.valid && req.ready;

endmodule

@@ src/fwt_queue.sv @@
// ============================================================================
// Fenwick tree command queue
// Two-entry queue that decouples the front end from the back end.
// ============================================================================
module fwt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fwt_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output fwt_pkg::cmd_t head
);
    import fwt_pkg::*;

    cmd_t       entry_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_pop)
            begin
                rptr_reg <= !rptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

@@ src/fwt_back.sv @@
// ============================================================================
// Fenwick tree back end
// Sequencer that owns the tree memory and carries out prefix walks, update
// walks, the lower bound descent and clearing sweeps, then posts the response.
// ============================================================================
module fwt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  fwt_pkg::cmd_t q_head,
    output logic          pop,
    output logic          init_busy,
    fwt_rsp_if.source     rsp
);
    import fwt_pkg::*;

    localparam logic [3:0] S_INIT    = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_PRE     = 4'd2;
    localparam logic [3:0] S_ADD_RD  = 4'd3;
    localparam logic [3:0] S_ADD_WR  = 4'd4;
    localparam logic [3:0] S_LB_RD   = 4'd5;
    localparam logic [3:0] S_LB_CMP  = 4'd6;
    localparam logic [3:0] S_CLR     = 4'd7;

    data_t mem [MAX_SIZE];
    data_t rd_data_reg;
    logic  mem_we;
    addr_t mem_waddr;
    data_t mem_wdata;
    addr_t mem_raddr;

    logic [3:0] state_reg,     state_next;
    cmd_t       cmd_reg,       cmd_next;
    data_t      acc_reg,       acc_next;
    wlk_t       pos_reg,       pos_next;
    logic       neg_reg,       neg_next;
    logic       walk2_reg,     walk2_next;
    logic       add_after_reg, add_after_next;
    logic       rd_pend_reg,   rd_pend_next;
    idx_t       lb_pos_reg,    lb_pos_next;
    idx_t       step_reg,      step_next;
    addr_t      clr_cnt_reg,   clr_cnt_next;
    logic       out_valid_reg, out_valid_next;
    data_t      result_reg,    result_next;
    logic       status_reg,    status_next;

    wlk_t       n_w;
    wlk_t       lb_nxt;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    assign n_w       = {1'b0, cmd_reg.n};
    assign lb_nxt    = {1'b0, lb_pos_reg} + {1'b0, step_reg};
    assign init_busy = (state_reg == S_INIT);
    assign pop       = (state_reg == S_IDLE) && q_valid && !out_valid_reg;

    assign rsp.valid  = out_valid_reg;
    assign rsp.result = result_reg;
    assign rsp.status = status_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        acc_next       = acc_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        walk2_next     = walk2_reg;
        add_after_next = add_after_reg;
        rd_pend_next   = 1'b0;
        lb_pos_next    = lb_pos_reg;
        step_next      = step_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        result_next    = result_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = ADDR_W'(pos_reg - WLK_W'(1));
        mem_wdata      = '0;
        mem_raddr      = ADDR_W'(pos_reg - WLK_W'(1));

        case (state_reg)
            S_INIT:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(MAX_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pop)
                begin
                    cmd_next       = q_head;
                    pos_next       = {1'b0, q_head.idx_a};
                    neg_next       = 1'b0;
                    walk2_next     = 1'b0;
                    add_after_next = 1'b0;
                    acc_next       = '0;
                    if (q_head.bad)
                    begin
                        out_valid_next = 1'b1;
                        result_next    = '0;
                        status_next    = 1'b1;
                    end
                    else
                    begin
                        case (q_head.op)
                            OP_ADD:
                            begin
                                acc_next   = q_head.value;
                                state_next = S_ADD_RD;
                            end
                            OP_SET:
                            begin
                                acc_next       = q_head.value;
                                neg_next       = 1'b1;
                                walk2_next     = 1'b1;
                                add_after_next = 1'b1;
                                state_next     = S_PRE;
                            end
                            OP_PREFIX:
                            begin
                                state_next = S_PRE;
                            end
                            OP_RANGE:
                            begin
                                pos_next   = {1'b0, q_head.idx_b};
                                walk2_next = 1'b1;
                                state_next = S_PRE;
                            end
                            OP_LOWER:
                            begin
                                acc_next    = q_head.value;
                                lb_pos_next = '0;
                                step_next   = q_head.lb_step;
                                state_next  = S_LB_RD;
                            end
                            OP_CLEAR:
                            begin
                                clr_cnt_next = '0;
                                state_next   = S_CLR;
                            end
                            default:
                            begin
                                out_valid_next = 1'b1;
                                result_next    = '0;
                                status_next    = 1'b0;
                            end
                        endcase
                    end
                end
            end
            S_PRE:
            begin
                if (pos_reg != '0)
                begin
                    pos_next     = pos_reg - low_bit(pos_reg);
                    rd_pend_next = 1'b1;
                end
                if (rd_pend_reg)
                begin
                    acc_next = neg_reg ? (acc_reg - rd_data_reg) : (acc_reg + rd_data_reg);
                end
                if ((pos_reg == '0) && !rd_pend_reg)
                begin
                    if (walk2_reg)
                    begin
                        pos_next   = {1'b0, cmd_reg.idx_am1};
                        neg_next   = !neg_reg;
                        walk2_next = 1'b0;
                    end
                    else if (add_after_reg)
                    begin
                        pos_next   = {1'b0, cmd_reg.idx_a};
                        state_next = S_ADD_RD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        result_next    = acc_reg;
                        status_next    = 1'b0;
                        state_next     = S_IDLE;
                    end
                end
            end
            S_ADD_RD:
            begin
                if (pos_reg <= n_w)
                begin
                    state_next = S_ADD_WR;
                end
                else
                begin
                    out_valid_next = 1'b1;
                    result_next    = '0;
                    status_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            S_ADD_WR:
            begin
                mem_we     = 1'b1;
                mem_wdata  = rd_data_reg + acc_reg;
                pos_next   = pos_reg + low_bit(pos_reg);
                state_next = S_ADD_RD;
            end
            S_LB_RD:
            begin
                mem_raddr = ADDR_W'(lb_nxt - WLK_W'(1));
                if (step_reg == '0)
                begin
                    out_valid_next = 1'b1;
                    result_next    = DATA_W'(lb_pos_reg) + DATA_W'(1);
                    status_next    = 1'b0;
                    state_next     = S_IDLE;
                end
                else if (lb_nxt <= n_w)
                begin
                    state_next = S_LB_CMP;
                end
                else
                begin
                    step_next = step_reg >> 1;
                end
            end
            S_LB_CMP:
            begin
                if (acc_reg > rd_data_reg)
                begin
                    lb_pos_next = lb_nxt[IDX_W-1:0];
                    acc_next    = acc_reg - rd_data_reg;
                end
                step_next  = step_reg >> 1;
                state_next = S_LB_RD;
            end
            S_CLR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(MAX_SIZE - 1))
                begin
                    out_valid_next = 1'b1;
                    result_next    = '0;
                    status_next    = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        acc_reg    <= acc_next;
        pos_reg    <= pos_next;
        neg_reg    <= neg_next;
        lb_pos_reg <= lb_pos_next;
        step_reg   <= step_next;
        result_reg <= result_next;
        status_reg <= status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            walk2_reg     <= 1'b0;
            add_after_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk2_reg     <= walk2_next;
            add_after_reg <= add_after_next;
            rd_pend_reg   <= rd_pend_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ src/fenwick_tree_prefix_sum.sv @@
// The back end works on one request at a time through its tree memory walks; the
// two-entry command queue lets the front end accept ahead.
// After reset the tree memory is swept to zero, all 1024 entries, with no request accepted.
// The size register resets to 1024.
// ============================================================================
// Fenwick tree prefix sum engine
// Binary indexed tree over positions 1..size (size clamped to 1..1024) with add, set, prefix sum,
// range sum, lower bound and clear requests.
// ============================================================================
module fenwick_tree_prefix_sum (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write_en,
    input  fwt_pkg::idx_t cfg_write_data,
    fwt_req_if.sink       req,
    fwt_rsp_if.source     rsp
);
    import fwt_pkg::*;

    logic push;
    cmd_t push_cmd;
    logic q_full;
    logic q_valid;
    cmd_t q_head;
    logic pop;
    logic init_busy;

    fwt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req),
        .q_full         (q_full),
        .init_busy      (init_busy),
        .push           (push),
        .cmd            (push_cmd)
    );

    fwt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (q_head)
    );

    fwt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .pop       (pop),
        .init_busy (init_busy),
        .rsp       (rsp)
    );

endmodule

@@ sim/fenwick_tree_prefix_sum_test.sv @@
`timescale 1ns / 100ps
// ============================================================================
// Fenwick tree prefix sum testbench
// Drives add, set, prefix sum, range sum, lower bound and clear requests
// through the request channel under several tree sizes and random idling on
// both channels. Each response word is checked against a cycle-free
// binary indexed tree kept alongside the block.
// ============================================================================
module fenwick_tree_prefix_sum_test;
    import fwt_pkg::*;

    localparam int    CYCLE_LIMIT  = 4000000;
    localparam int    PHASE_ITEMS  = 70;
    localparam int    LONG_HOLD    = 400;
    localparam int    LONG_HOLD_AT = 120;
    localparam idx_t  SIZE_RESET   = 11'd1024;
    localparam op_t   OP_SPARE_LO  = 3'd6;
    localparam op_t   OP_SPARE_HI  = 3'd7;
    localparam logic  ST_OK        = 1'b0;
    localparam logic  ST_RANGE     = 1'b1;
    localparam data_t DATA_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam data_t DATA_MIN     = 64'h8000_0000_0000_0000;

    typedef struct {
        op_t   op;
        idx_t  a;
        idx_t  b;
        data_t v;
    } req_word_t;

    typedef struct {
        data_t result;
        logic  status;
    } tree_rsp_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write_en;
    idx_t cfg_write_data;

    fwt_req_if req_ch ();
    fwt_rsp_if rsp_ch ();

    fenwick_tree_prefix_sum dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .req            (req_ch.sink),
        .rsp            (rsp_ch.source)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [63:0] tree_words [1:MAX_SIZE];
    idx_t        size_reg = SIZE_RESET;
    req_word_t   req_backlog [$];
    tree_rsp_t   rsp_due [$];
    int          queued_count = 0;
    int          accepted_count = 0;
    int          rsp_count = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    logic        req_fired = 1'b0;
    logic        rsp_fired = 1'b0;
    int          send_gap = 0;
    bit          send_burst = 1'b0;
    int          take_gap = 0;
    bit          take_burst = 1'b0;
    bit          long_hold_done = 1'b0;

    function automatic int unsigned span_of(idx_t s);
        if (s < 1)
            return 1;
        if (s > MAX_SIZE)
            return MAX_SIZE;
        return s;
    endfunction

    function automatic void tree_bump(int unsigned pos, logic [63:0] delta, int unsigned n);
        while (pos >= 1 && pos <= n)
        begin
            tree_words[pos] += delta;
            pos += pos & (~pos + 1);
        end
    endfunction

    function automatic logic [63:0] tree_prefix(int unsigned pos, int unsigned n);
        logic [63:0] acc;
        acc = '0;
        if (pos > n)
            pos = n;
        while (pos > 0)
        begin
            acc += tree_words[pos];
            pos -= pos & (~pos + 1);
        end
        return acc;
    endfunction

    function automatic logic [63:0] tree_search(logic [63:0] target, int unsigned n);
        int unsigned pos;
        int unsigned step;
        int unsigned nxt;
        pos  = 0;
        step = 1;
        while ((step << 1) <= n)
            step <<= 1;
        for (; step != 0; step >>= 1)
        begin
            nxt = pos + step;
            if (nxt <= n && $signed(target) > $signed(tree_words[nxt]))
            begin
                pos = nxt;
                target -= tree_words[nxt];
            end
        end
        return 64'(pos) + 64'd1;
    endfunction

    function automatic tree_rsp_t tree_response(req_word_t w);
        tree_rsp_t   r;
        int unsigned n;
        bit          a_bad;
        bit          b_bad;
        n      = span_of(size_reg);
        a_bad  = (w.a < 1) || (w.a > n);
        b_bad  = (w.b < 1) || (w.b > n);
        r.result = '0;
        r.status = ST_OK;
        case (w.op)
            OP_ADD:
                if (a_bad)
                    r.status = ST_RANGE;
                else
                    tree_bump(w.a, w.v, n);
            OP_SET:
                if (a_bad)
                    r.status = ST_RANGE;
                else
                    tree_bump(w.a, w.v - tree_prefix(w.a, n) + tree_prefix(w.a - 1, n), n);
            OP_PREFIX:
                if (a_bad)
                    r.status = ST_RANGE;
                else
                    r.result = tree_prefix(w.a, n);
            OP_RANGE:
                if (a_bad || b_bad)
                    r.status = ST_RANGE;
                else
                    r.result = tree_prefix(w.b, n) - tree_prefix(w.a - 1, n);
            OP_LOWER:
                r.result = tree_search(w.v, n);
            OP_CLEAR:
                for (int i = 1; i <= MAX_SIZE; i++)
                    tree_words[i] = '0;
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic data_t wide_word();
        return {$urandom, $urandom};
    endfunction

    function automatic idx_t pick_index(int unsigned n);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 92)
            return idx_t'($urandom_range(1, n));
        if (r < 95)
            return '0;
        if (r < 97)
            return idx_t'(n + 1);
        return idx_t'($urandom_range(0, 2047));
    endfunction

    function automatic req_word_t random_request(int unsigned n);
        req_word_t   w;
        int unsigned pick;
        int unsigned r;
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 99);
        w.a  = pick_index(n);
        w.b  = pick_index(n);
        w.v  = (r < 85) ? data_t'($urandom_range(0, 1000)) : wide_word();
        if (pick < 30)
            w.op = OP_ADD;
        else if (pick < 42)
            w.op = OP_SET;
        else if (pick < 57)
            w.op = OP_PREFIX;
        else if (pick < 72)
            w.op = OP_RANGE;
        else if (pick < 88)
        begin
            w.op = OP_LOWER;
            if (r < 70)
                w.v = data_t'($urandom_range(0, 5000));
            else if (r < 85)
                w.v = -data_t'($urandom_range(0, 100));
            else
                w.v = wide_word();
        end
        else if (pick < 90)
            w.op = OP_CLEAR;
        else if (pick < 94)
            w.op = $urandom_range(0, 1) ? OP_SPARE_LO : OP_SPARE_HI;
        else
        begin
            w.op = op_t'($urandom_range(0, 7));
            w.a  = idx_t'($urandom_range(0, 2047));
            w.b  = idx_t'($urandom_range(0, 2047));
            w.v  = wide_word();
        end
        return w;
    endfunction

    task automatic push_req(op_t op, idx_t a, idx_t b, data_t v);
        req_word_t w;
        w.op = op;
        w.a  = a;
        w.b  = b;
        w.v  = v;
        req_backlog.push_back(w);
        queued_count++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (accepted_count != queued_count || rsp_due.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_size(idx_t s);
        @(negedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= s;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        @(posedge clk);
    endtask

    // Request driver.
    always @(negedge clk)
    begin
        req_word_t w;
        if (rst_n)
        begin
            if (req_ch.valid && !req_fired)
            begin
            end
            else if (send_gap > 0)
            begin
                send_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (req_backlog.size() > 0)
            begin
                w = req_backlog.pop_front();
                req_ch.valid   <= 1'b1;
                req_ch.opcode  <= w.op;
                req_ch.index_a <= w.a;
                req_ch.index_b <= w.b;
                req_ch.value   <= w.v;
                if ($urandom_range(0, 39) == 0)
                    send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 11);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // Response taker.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_fired)
            begin
                if ($urandom_range(0, 39) == 0)
                    take_burst = !take_burst;
                take_gap = take_burst ? 0 : $urandom_range(0, 11);
                if (rsp_count == LONG_HOLD_AT && !long_hold_done)
                begin
                    take_gap       = LONG_HOLD;
                    long_hold_done = 1'b1;
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Prediction and checking.
    always @(posedge clk)
    begin
        req_word_t w;
        tree_rsp_t due;
        if (cfg_write_en)
            size_reg = cfg_write_data;
        req_fired <= req_ch.valid && req_ch.ready;
        rsp_fired <= rsp_ch.valid && rsp_ch.ready;
        if (req_ch.valid && req_ch.ready)
        begin
            w.op = req_ch.opcode;
            w.a  = req_ch.index_a;
            w.b  = req_ch.index_b;
            w.v  = req_ch.value;
            rsp_due.push_back(tree_response(w));
            accepted_count++;
        end
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_count <= rsp_count + 1;
            if (rsp_due.size() == 0)
            begin
                $error("response word with nothing pending: result %0d status %0d",
                       rsp_ch.result, rsp_ch.status);
                error_count++;
            end
            else
            begin
                due = rsp_due.pop_front();
                if (rsp_ch.result !== due.result)
                begin
                    $error("result: expected %0d, actual %0d", due.result, rsp_ch.result);
                    error_count++;
                end
                if (rsp_ch.status !== due.status)
                begin
                    $error("status: expected %0d, actual %0d", due.status, rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[fenwick_tree_prefix_sum] ERROR");
            $finish;
        end
    end

    initial
    begin
        idx_t        plan [0:9];
        int unsigned n;
        plan = '{11'd2047, 11'd1, 11'd0, 11'd7, 11'd16, 11'd1000, 11'd0, 11'd513,
                 11'd1024, 11'd0};
        plan[6] = idx_t'($urandom_range(2, 64));
        plan[9] = idx_t'($urandom_range(0, 2047));
        for (int i = 1; i <= MAX_SIZE; i++)
            tree_words[i] = '0;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        req_ch.valid   = 1'b0;
        req_ch.opcode  = OP_ADD;
        req_ch.index_a = '0;
        req_ch.index_b = '0;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_req(OP_ADD, 11'd1, 11'd0, 64'sd5);
        push_req(OP_ADD, 11'd1024, 11'd0, DATA_MAX);
        push_req(OP_ADD, 11'd1024, 11'd0, -64'sd1);
        push_req(OP_SET, 11'd512, 11'd0, DATA_MIN);
        push_req(OP_SET, 11'd3, 11'd0, 64'sd0);
        push_req(OP_PREFIX, 11'd1, 11'd0, 64'sd0);
        push_req(OP_PREFIX, 11'd1024, 11'd0, 64'sd0);
        push_req(OP_RANGE, 11'd1, 11'd1024, 64'sd0);
        push_req(OP_RANGE, 11'd1000, 11'd3, 64'sd0);
        push_req(OP_RANGE, 11'd0, 11'd5, 64'sd0);
        push_req(OP_RANGE, 11'd5, 11'd1025, 64'sd0);
        push_req(OP_RANGE, 11'd2, 11'd2047, 64'sd0);
        push_req(OP_ADD, 11'd0, 11'd0, 64'sd7);
        push_req(OP_ADD, 11'd1025, 11'd0, 64'sd7);
        push_req(OP_SET, 11'd2047, 11'd0, -64'sd1);
        push_req(OP_PREFIX, 11'd0, 11'd0, 64'sd0);
        push_req(OP_SPARE_LO, 11'd2047, 11'd2047, -64'sd1);
        push_req(OP_SPARE_HI, 11'd1, 11'd1, 64'sd3);
        push_req(OP_LOWER, 11'd0, 11'd0, 64'sd0);
        push_req(OP_LOWER, 11'd0, 11'd0, DATA_MIN);
        push_req(OP_CLEAR, 11'd0, 11'd0, 64'sd0);
        push_req(OP_ADD, 11'd700, 11'd0, 64'sd9);
        push_req(OP_LOWER, 11'd0, 11'd0, 64'sd9);
        push_req(OP_LOWER, 11'd0, 11'd0, 64'sd10);
        push_req(OP_PREFIX, 11'd1024, 11'd0, 64'sd0);
        wait_drained();

        for (int p = 0; p < 10; p++)
        begin
            write_size(plan[p]);
            n = span_of(plan[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                req_backlog.push_back(random_request(n));
                queued_count++;
            end
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("[fenwick_tree_prefix_sum] OK");
        else
            $display("[fenwick_tree_prefix_sum] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/fwt_pkg.sv
src/fwt_req_if.sv
src/fwt_rsp_if.sv
src/fwt_front.sv
src/fwt_queue.sv
src/fwt_back.sv
src/fenwick_tree_prefix_sum.sv
sim/fenwick_tree_prefix_sum_test.sv
